FILE: hw/rtl/brhm_pkg.sv
package brhm_pkg;

  localparam int MAX_ROW_WORDS = 64;
  localparam int WORD_W        = 32;
  localparam int ADDR_W        = $clog2(MAX_ROW_WORDS);
  localparam int CNT_W         = 7;
  localparam int WIDTH_W       = 12;
  localparam int SHIFT_W       = $clog2(WORD_W);
  localparam int CFG_IDX_W     = 2;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'(MAX_ROW_WORDS * WORD_W);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic               load_a;
    logic               emit;
    logic               use_b;
    logic               last;
    logic [SHIFT_W-1:0] shift;
  } emit_ctl_t;

  function automatic word_t bit_rev(input word_t w);
    word_t r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = w[WORD_W-1-i];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/brhm_ram.sv
module brhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/brhm_mirror.sv
module brhm_mirror (
  input  logic                clk,
  input  logic                rst_n,
  input  brhm_pkg::emit_ctl_t ctl,
  input  brhm_pkg::word_t     rdata,
  output logic                out_valid,
  output brhm_pkg::word_t     out_word,
  output logic                out_last
);
  import brhm_pkg::*;

  word_t              a_r;
  word_t              b_rev;
  logic [2*WORD_W-1:0] pair;
  logic [2*WORD_W-1:0] shifted;
  logic               valid_r;
  word_t              word_r;
  logic               last_r;

  assign b_rev   = ctl.use_b ? bit_rev(rdata) : '0;
  assign pair    = {a_r, b_rev};
  assign shifted = pair << ctl.shift;

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      a_r <= bit_rev(rdata);
    end
    if (ctl.emit) begin
      word_r <= shifted[2*WORD_W-1:WORD_W];
      last_r <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.emit;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign out_last  = last_r;

endmodule

FILE: hw/rtl/binary_row_horizontal_mirror_core.sv
// horizontal mirror of 1 bpp image rows, 32 pixels per word, pixel 0 in bit 31
// input: a word is taken when start is high and busy is low; words of a row
//   are stored one per cycle (optionally inverted) until the word count
//   reaches ceil(width/32) for the configured row width
// output: after the last word of a row the block is busy while it emits the row;
//   mirrored words appear one per cycle on out_valid, last_of_row on the last
// throughput: words of a row are stored one per cycle while idle, and no word is
//   taken while a row is emitted; the single read port of the line store paces emit
// config: cfg_index 0 row width in pixels (0 reads as 1, above 2048 as 2048),
//   1 input invert; always ready, write only while idle
// reset: word count and control clear, row width resets to 1 and invert to 0; the
//   line store is not cleared and needs no clearing pass
// the receiver cannot stall: each result is valid for exactly one cycle
module binary_row_horizontal_mirror_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [31:0]                      in_pixel_word,
  output logic                             out_valid,
  output logic [31:0]                      out_mirrored_word,
  output logic                             out_last_of_row,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [brhm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brhm_pkg::WIDTH_W-1:0]     cfg_data
);
  import brhm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic               state_r, state_nxt;
  logic [WIDTH_W-1:0] width_r;
  logic               invert_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   nw_r, nw_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;

  logic [WIDTH_W-1:0] weff;
  logic [WIDTH_W:0]   wsum;
  logic [CNT_W-1:0]   nwords;
  logic [CNT_W-1:0]   cnt_inc;
  logic               accept;
  logic               row_end;
  logic [CNT_W-1:0]   final_step;
  logic               re;
  logic [ADDR_W-1:0]  raddr;
  logic [CNT_W-1:0]   raddr_full;
  word_t              wdata;
  word_t              rdata;
  emit_ctl_t          ctl;

  always_comb begin
    if (width_r == '0) begin
      weff = WIDTH_W'(1);
    end else if (width_r > MAX_WIDTH) begin
      weff = MAX_WIDTH;
    end else begin
      weff = width_r;
    end
  end

  assign wsum    = {1'b0, weff} + (WIDTH_W+1)'(WORD_W - 1);
  assign nwords  = wsum[SHIFT_W +: CNT_W];
  assign cnt_inc = count_r + CNT_W'(1);
  assign accept  = start && (state_r == ST_IDLE);
  assign row_end = cnt_inc >= nwords;
  assign wdata   = invert_r ? ~in_pixel_word : in_pixel_word;

  assign final_step = nw_r + CNT_W'(1);
  assign raddr_full = nw_r - CNT_W'(1) - step_r;
  assign raddr      = raddr_full[ADDR_W-1:0];
  assign re         = (state_r == ST_EMIT) && (step_r < nw_r);

  always_comb begin
    ctl.load_a = (state_r == ST_EMIT) && (step_r != '0) && (step_r <= nw_r);
    ctl.emit   = (state_r == ST_EMIT) && (step_r >= CNT_W'(2));
    ctl.use_b  = step_r <= nw_r;
    ctl.last   = step_r == final_step;
    ctl.shift  = shift_r;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    nw_nxt    = nw_r;
    shift_nxt = shift_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (row_end) begin
            count_nxt = '0;
            nw_nxt    = nwords;
            shift_nxt = SHIFT_W'(~weff[SHIFT_W-1:0] + SHIFT_W'(1));
            step_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            count_nxt = cnt_inc;
          end
        end
      end
      ST_EMIT: begin
        if (step_r == final_step) begin
          state_nxt = ST_IDLE;
        end else begin
          step_nxt = step_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      width_r  <= WIDTH_W'(1);
      invert_r <= 1'b0;
      step_r   <= '0;
      nw_r     <= CNT_W'(1);
      shift_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      nw_r    <= nw_nxt;
      shift_r <= shift_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_WIDTH: width_r  <= cfg_data;
          REG_INVERT:    invert_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  brhm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_ROW_WORDS)
  ) u_line_store (
    .clk  (clk),
    .we   (accept),
    .waddr(count_r[ADDR_W-1:0]),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  brhm_mirror u_mirror (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rdata    (rdata),
    .out_valid(out_valid),
    .out_word (out_mirrored_word),
    .out_last (out_last_of_row)
  );

  assign busy      = (state_r == ST_EMIT);
  assign cfg_ready = 1'b1;

endmodule

FILE: tb/row_mirror_checker.sv
`timescale 1ns / 1ps

module row_mirror_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [31:0]                    in_pixel_word,
  input  logic                           out_valid,
  input  logic [31:0]                    out_mirrored_word,
  input  logic                           out_last_of_row,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [brhm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brhm_pkg::WIDTH_W-1:0]   cfg_data,
  output int                             fail_count,
  output int                             pending
);

  import brhm_pkg::*;

  typedef struct packed {
    word_t pixels;
    logic  last;
  } mirror_beat_t;

  mirror_beat_t       mirrored_q[$];
  word_t              row_store [MAX_ROW_WORDS];
  logic [CNT_W-1:0]   row_words_seen;
  logic [WIDTH_W-1:0] width_reg;
  logic               invert_reg;

  task automatic take_word(input word_t px);
    int           eff;
    int           nw;
    int           q;
    word_t        acc;
    mirror_beat_t beat;
    eff = (width_reg == '0) ? 1 : int'(width_reg);
    if (eff > MAX_ROW_WORDS * WORD_W) eff = MAX_ROW_WORDS * WORD_W;
    nw = (eff + WORD_W - 1) / WORD_W;
    row_store[row_words_seen[ADDR_W-1:0]] = invert_reg ? ~px : px;
    row_words_seen = row_words_seen + 1'b1;
    if (int'(row_words_seen) >= nw) begin
      for (int k = 0; k < nw; k++) begin
        acc = '0;
        for (int b = 0; b < WORD_W; b++) begin
          if (k * WORD_W + b < eff) begin
            q = eff - 1 - (k * WORD_W + b);
            acc[WORD_W-1-b] = row_store[q / WORD_W][WORD_W - 1 - (q % WORD_W)];
          end
        end
        beat.pixels = acc;
        beat.last   = (k == nw - 1);
        mirrored_q.push_back(beat);
      end
      row_words_seen = '0;
    end
  endtask

  always @(posedge clk) begin
    mirror_beat_t want;
    if (!rst_n) begin
      mirrored_q.delete();
      row_words_seen = '0;
      width_reg      = WIDTH_W'(1);
      invert_reg     = 1'b0;
    end else begin
      if (out_valid) begin
        if (mirrored_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat, expected none, actual %h last %b",
                   $time, out_mirrored_word, out_last_of_row);
        end else begin
          want = mirrored_q.pop_front();
          if (out_mirrored_word !== want.pixels || out_last_of_row !== want.last) begin
            fail_count++;
            $display("%0t: expected %h last %b, actual %h last %b", $time,
                     want.pixels, want.last, out_mirrored_word, out_last_of_row);
          end
        end
      end
      if (start && !busy) take_word(in_pixel_word);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_WIDTH: width_reg = cfg_data;
          REG_INVERT:    invert_reg = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = mirrored_q.size();
  end

endmodule

FILE: tb/tb_binary_row_horizontal_mirror_core.sv
`timescale 1ns / 1ps

module tb_binary_row_horizontal_mirror_core;

  import brhm_pkg::*;

  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 72;
  localparam int TAIL_CYCLES   = 80;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [31:0]          in_pixel_word = '0;
  logic                 out_valid;
  logic [31:0]          out_mirrored_word;
  logic                 out_last_of_row;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDTH_W-1:0]   cfg_data = '0;

  int fail_count;
  int pending;
  int idle_pct = 0;
  int cycles = 0;

  always #10 clk = ~clk;

  binary_row_horizontal_mirror_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_pixel_word     (in_pixel_word),
    .out_valid         (out_valid),
    .out_mirrored_word (out_mirrored_word),
    .out_last_of_row   (out_last_of_row),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  row_mirror_checker mirror_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_pixel_word     (in_pixel_word),
    .out_valid         (out_valid),
    .out_mirrored_word (out_mirrored_word),
    .out_last_of_row   (out_last_of_row),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles == RUN_LIMIT) begin
      $display("binary_row_horizontal_mirror_core: mismatch");
      $finish;
    end
  end

  function automatic int words_per_row(input int w);
    int e;
    e = (w == 0) ? 1 : w;
    if (e > MAX_ROW_WORDS * WORD_W) e = MAX_ROW_WORDS * WORD_W;
    return (e + WORD_W - 1) / WORD_W;
  endfunction

  function automatic word_t rand_pixels();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(WORD_W - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input word_t px);
    start         <= 1'b1;
    in_pixel_word <= px;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // hold the sender off until every mirrored beat is back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] data);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int width, input logic inv, input int pct, input int budget);
    int                 row_n;
    int                 part;
    int                 sent;
    logic [WIDTH_W-1:0] inv_data;
    idle_pct = pct;
    inv_data = WIDTH_W'($urandom);
    inv_data[0] = inv;
    cfg_write(REG_ROW_WIDTH, WIDTH_W'(width));
    cfg_write(REG_INVERT, inv_data);
    sent = 0;
    while (sent < budget) begin
      row_n = words_per_row(width);
      // broken row: settings change partway through
      if (row_n > 1 && row_n < MAX_ROW_WORDS && $urandom_range(7) == 0) begin
        part = $urandom_range(1, row_n - 1);
        repeat (part) send_word(rand_pixels());
        if ($urandom_range(1) == 1) begin
          cfg_write(REG_INVERT, WIDTH_W'($urandom));
          row_n = row_n - part;
        end else begin
          width = $urandom_range(0, 300);
          cfg_write(REG_ROW_WIDTH, WIDTH_W'(width));
          row_n = (part >= words_per_row(width)) ? 1 : words_per_row(width) - part;
        end
        sent += part;
      end
      repeat (row_n) send_word(rand_pixels());
      sent += row_n;
      if ($urandom_range(15) == 0) drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    cfg_write(REG_ROW_WIDTH, '0);
    send_word('1);
    cfg_write(REG_SPARE_3, 12'hABC);
    cfg_write(REG_SPARE_2, 12'h543);
    cfg_write(REG_ROW_WIDTH, 12'd32);
    send_word(32'h1234_5678);
    cfg_write(REG_ROW_WIDTH, 12'd33);
    send_word('1);
    send_word(32'h8000_0000);
    cfg_write(REG_ROW_WIDTH, 12'd7);
    cfg_write(REG_INVERT, 12'hFFF);
    send_word('0);
    cfg_write(REG_ROW_WIDTH, 12'd64);
    cfg_write(REG_INVERT, 12'h000);
    send_word(32'hF0F0_1234);
    cfg_write(REG_INVERT, 12'h001);
    send_word(32'h0000_FFFF);
    cfg_write(REG_INVERT, 12'hFFE);
    cfg_write(REG_ROW_WIDTH, 12'd96);
    send_word(32'hDEAD_BEEF);
    send_word(32'h0123_4567);
    cfg_write(REG_ROW_WIDTH, 12'd40);
    send_word(32'h89AB_CDEF);
    cfg_write(REG_ROW_WIDTH, 12'd64);
    send_word(32'hC000_0003);
    cfg_write(REG_ROW_WIDTH, 12'd96);
    send_word(32'h5555_5555);
    send_word(32'h3333_3333);
    cfg_write(REG_ROW_WIDTH, 12'd31);
    send_word(32'hAAAA_AAAA);

    run_phase($urandom_range(1, 64), 1'b0, 0, 12);
    run_phase($urandom_range(301, 700), 1'b1, 25, 20);
    run_phase($urandom_range(65, 300), 1'($urandom_range(1)), 88, 12);
    run_phase((1 << WIDTH_W) - 1, 1'b0, 0, 1);
    run_phase(0, 1'b1, 25, 8);
    run_phase($urandom_range(1, 300), 1'($urandom_range(1)), 88, 12);
    run_phase($urandom_range(1, 1023), 1'($urandom_range(1)), 0, 1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("binary_row_horizontal_mirror_core: match");
    end else begin
      $display("binary_row_horizontal_mirror_core: mismatch");
    end
    $finish;
  end

endmodule
